// ===== hdl/utf8d_pkg.sv =====
// shared types, constants and functions of the utf-8 stream decoder
package utf8d_pkg;

  localparam int MAX_SEQ_BYTES = 6;
  localparam int CP_W = 31;
  localparam int LEN_W = 3;
  localparam int LEAD_W = 4;

  // one decode outcome handed from the step logic to the result register
  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             bad_sequence;
  } res_t;

  // number of leading one bits of a byte, 0 to 8
  function automatic logic [LEAD_W-1:0] lead_ones(input logic [7:0] b);
    logic [LEAD_W-1:0] n;
    casez (b)
      8'b0???????: n = 4'd0;
      8'b10??????: n = 4'd1;
      8'b110?????: n = 4'd2;
      8'b1110????: n = 4'd3;
      8'b11110???: n = 4'd4;
      8'b111110??: n = 4'd5;
      8'b1111110?: n = 4'd6;
      8'b11111110: n = 4'd7;
      default:     n = 4'd8;
    endcase
    return n;
  endfunction

  // payload bits of a lead byte with n leading ones
  function automatic logic [7:0] lead_bits(input logic [7:0] b, input logic [LEAD_W-1:0] n);
    logic [7:0] mask;
    mask = 8'hFF >> (n + 4'd1);
    return b & mask;
  endfunction

endpackage

// ===== hdl/utf8d_step.sv =====
// sequence state and per-byte decode step
module utf8d_step (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [7:0]                byte_val,
  output utf8d_pkg::res_t           res
);
  import utf8d_pkg::*;

  logic [CP_W-1:0]   partial_value, partial_value_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic [LEN_W-1:0]  total_length, total_length_next;
  logic [LEAD_W-1:0] n;
  logic [CP_W-1:0]   shifted;
  logic              is_cont;

  assign n       = lead_ones(byte_val);
  assign is_cont = (byte_val[7:6] == 2'b10);
  assign shifted = {partial_value[CP_W-7:0], byte_val[5:0]};

  // decode one byte against the open sequence
  always_comb begin
    partial_value_next = partial_value;
    bytes_left_next    = bytes_left;
    total_length_next  = total_length;
    res                = '0;
    if (bytes_left != '0) begin
      if (is_cont) begin
        bytes_left_next = bytes_left - LEN_W'(1);
        if (bytes_left == LEN_W'(1)) begin
          res.valid          = 1'b1;
          res.code_point     = shifted;
          res.seq_length     = total_length;
          partial_value_next = '0;
          total_length_next  = '0;
        end else begin
          partial_value_next = shifted;
        end
      end else begin
        // broken sequence: drop it together with the offending byte
        res.valid          = 1'b1;
        res.bad_sequence   = 1'b1;
        res.seq_length     = total_length - bytes_left + LEN_W'(1);
        partial_value_next = '0;
        bytes_left_next    = '0;
        total_length_next  = '0;
      end
    end else if (n == '0) begin
      res.valid      = 1'b1;
      res.code_point = CP_W'(byte_val);
      res.seq_length = LEN_W'(1);
    end else if (n < LEAD_W'(2) || n >= LEAD_W'(7) || n > LEAD_W'(MAX_SEQ_BYTES)) begin
      // stray continuation, invalid lead or sequence too long
      res.valid        = 1'b1;
      res.bad_sequence = 1'b1;
      res.seq_length   = LEN_W'(1);
    end else begin
      partial_value_next = CP_W'(lead_bits(byte_val, n));
      bytes_left_next    = LEN_W'(n - LEAD_W'(1));
      total_length_next  = LEN_W'(n);
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_left    <= '0;
      total_length  <= '0;
    end else if (advance) begin
      partial_value <= partial_value_next;
      bytes_left    <= bytes_left_next;
      total_length  <= total_length_next;
    end
  end

endmodule

// ===== hdl/utf8d_out_reg.sv =====
// result register on the output channel
module utf8d_out_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  utf8d_pkg::res_t             res,
  input  logic                        out_ready,
  output logic                        out_free,
  output logic                        out_valid,
  output logic [utf8d_pkg::CP_W-1:0]  code_point,
  output logic [utf8d_pkg::LEN_W-1:0] seq_length,
  output logic                        bad_sequence
);
  import utf8d_pkg::*;

  assign out_free = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      code_point   <= res.code_point;
      seq_length   <= res.seq_length;
      bad_sequence <= res.bad_sequence;
    end
  end

endmodule

// ===== hdl/utf8_stream_decoder.sv =====
// utf-8 stream decoder top level: input register, decode step, result register
// a result passes the input register, then the result register when that is free
// throughput: one byte per cycle while the output side keeps taking results
// bytes that only extend a sequence never wait for the output register
// reset (synchronous, active high) empties both registers and closes any open sequence
module utf8_stream_decoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  byte_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [utf8d_pkg::CP_W-1:0]  code_point,
  output logic [utf8d_pkg::LEN_W-1:0] seq_length,
  output logic                        bad_sequence
);
  import utf8d_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       process;
  logic       out_free;
  res_t       step_res;

  // a held byte moves on unless its result finds the output register full
  assign process  = held_valid && (!step_res.valid || out_free);
  assign in_ready = !held_valid || process;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= byte_in;
    end
  end

  utf8d_step u_step (
    .clk      (clk),
    .rst      (rst),
    .advance  (process),
    .byte_val (held_byte),
    .res      (step_res)
  );

  utf8d_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (process && step_res.valid),
    .res          (step_res),
    .out_ready    (out_ready),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .code_point   (code_point),
    .seq_length   (seq_length),
    .bad_sequence (bad_sequence)
  );

endmodule

// ===== hdl/utf8d_checker.sv =====
// port-level checks of the utf-8 stream decoder, bound to the top level
module utf8d_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [utf8d_pkg::CP_W-1:0]  code_point,
  input logic [utf8d_pkg::LEN_W-1:0] seq_length,
  input logic                        bad_sequence
);
  import utf8d_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(seq_length)
      && $stable(bad_sequence))
    else $error("result changed while stalled");

  // an error result carries no code point
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_sequence |-> code_point == '0)
    else $error("error result with nonzero code point");

  // a good single-byte result is ascii
  a_single_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_sequence && seq_length == LEN_W'(1) |-> code_point < CP_W'(128))
    else $error("single-byte result out of ascii range");

  // length stays within the sequence limit
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seq_length != '0 && seq_length <= LEN_W'(MAX_SEQ_BYTES))
    else $error("sequence length out of range");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .code_point   (code_point),
  .seq_length   (seq_length),
  .bad_sequence (bad_sequence)
);

// ===== sim/utf8_stream_decoder_tb.sv =====
// self-checking testbench for the utf-8 stream decoder: directed table, then random text
module utf8_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  // one decoded character or error as seen on the output side
  typedef struct packed {
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             bad;
  } char_result_t;

  // one row of the directed table; typed rows carry their own result
  typedef struct packed {
    logic [7:0]       b;
    logic             typed;
    logic [CP_W-1:0]  cp;
    logic [LEN_W-1:0] len;
    logic             bad;
  } byte_row_t;

  // output side stall behaviour, changed every stretch
  typedef enum logic [1:0] {
    DRAIN_FREE,
    DRAIN_COIN,
    DRAIN_TRICKLE
  } drain_mode_t;

  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_BYTES = 550;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_LIMIT = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       byte_in = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CP_W-1:0]  code_point;
  logic [LEN_W-1:0] seq_length;
  logic             bad_sequence;

  // decoder state as the predictor sees it
  logic [CP_W-1:0]  seq_value = '0;
  logic [LEN_W-1:0] seq_left = '0;
  logic [LEN_W-1:0] seq_total = '0;

  char_result_t pending_chars[$];
  logic [7:0]   text_bytes[$];
  int           fail_count = 0;
  int           burst_left = 0;
  drain_mode_t  drain_mode = DRAIN_FREE;
  int           drain_run = 0;

  byte_row_t directed_rows [DIRECTED_ROWS] = '{
    // single bytes: ascii extremes, stray continuation, illegal leads
    '{8'h00, 1'b1, 31'h0000_0000, 3'd1, 1'b0},
    '{8'h7F, 1'b1, 31'h0000_007F, 3'd1, 1'b0},
    '{8'h80, 1'b1, 31'h0000_0000, 3'd1, 1'b1},
    '{8'hFE, 1'b1, 31'h0000_0000, 3'd1, 1'b1},
    '{8'hFF, 1'b1, 31'h0000_0000, 3'd1, 1'b1},
    // smallest two byte value
    '{8'hC0, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'h80, 1'b0, 31'h0, 3'd0, 1'b0},
    // largest three byte value
    '{8'hEF, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 31'h0, 3'd0, 1'b0},
    // largest six byte value, all code point bits set
    '{8'hFD, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hBF, 1'b0, 31'h0, 3'd0, 1'b0},
    // sequence broken by an ascii byte
    '{8'hE1, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'h41, 1'b1, 31'h0000_0000, 3'd2, 1'b1},
    // five byte sequence broken by an illegal lead
    '{8'hF8, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'h80, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'h80, 1'b0, 31'h0, 3'd0, 1'b0},
    '{8'hFF, 1'b1, 31'h0000_0000, 3'd4, 1'b1}
  };

  utf8_stream_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_in      (byte_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .code_point   (code_point),
    .seq_length   (seq_length),
    .bad_sequence (bad_sequence)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // back to idle after a character or an error
  function automatic void close_sequence();
    seq_value = '0;
    seq_left  = '0;
    seq_total = '0;
  endfunction

  // advance the decoder state by one byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic [7:0] b, output char_result_t r);
    int unsigned ones;
    r = '0;
    // inside an open sequence
    if (seq_left != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_value = {seq_value[CP_W-7:0], b[5:0]};
        seq_left  = seq_left - 1'b1;
        if (seq_left == 0) begin
          r.cp  = seq_value;
          r.len = seq_total;
          close_sequence();
          return 1'b1;
        end
        return 1'b0;
      end
      r.len = seq_total - seq_left + 1'b1;
      r.bad = 1'b1;
      close_sequence();
      return 1'b1;
    end
    // ascii stands alone
    if (!b[7]) begin
      r.cp  = CP_W'(b);
      r.len = 3'd1;
      return 1'b1;
    end
    // lead byte, or a stray continuation
    ones = 0;
    while (ones < 8 && b[7-ones]) ones++;
    if (ones < 2 || ones >= 7 || ones > MAX_SEQ_BYTES) begin
      r.len = 3'd1;
      r.bad = 1'b1;
      return 1'b1;
    end
    seq_value = CP_W'(b & (8'hFF >> (ones + 1)));
    seq_left  = LEN_W'(ones - 1);
    seq_total = LEN_W'(ones);
    return 1'b0;
  endfunction

  // one input transfer, with bursts and random gaps between them
  task automatic transfer_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // record a failure; only the first few are printed
  task automatic flag_mismatch(input string what, input char_result_t want,
                               input char_result_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("mismatch at %0t: %s: expected cp=%h len=%0d bad=%0b, got cp=%h len=%0d bad=%0b",
               $realtime, what, want.cp, want.len, want.bad, got.cp, got.len, got.bad);
  endtask

  // random text: mostly good characters, some broken sequences and noise
  task automatic build_random_text();
    int kind;
    int n;
    int k;
    while (text_bytes.size() < RANDOM_BYTES) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        n = ($urandom_range(0, 4) == 0) ? 6 : $urandom_range(1, 6);
        if (n == 1) begin
          text_bytes.push_back(8'($urandom_range(0, 127)));
        end else begin
          text_bytes.push_back(~(8'hFF >> n) | (8'($urandom) & (8'hFF >> (n + 1))));
          repeat (n - 1) text_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
      end else if (kind < 75) begin
        n = $urandom_range(2, 6);
        k = $urandom_range(0, n - 2);
        text_bytes.push_back(~(8'hFF >> n) | (8'($urandom) & (8'hFF >> (n + 1))));
        repeat (k) text_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        if ($urandom_range(0, 1) == 0)
          text_bytes.push_back(8'($urandom_range(0, 127)));
        else
          text_bytes.push_back(8'($urandom_range(192, 255)));
      end else if (kind < 88) begin
        text_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // output side stalls in stretches of varying behaviour
  always @(posedge clk) begin
    if (drain_run == 0) begin
      drain_mode <= drain_mode_t'($urandom_range(0, 2));
      drain_run  <= $urandom_range(4, 40);
    end else begin
      drain_run <= drain_run - 1;
    end
    case (drain_mode)
      DRAIN_FREE:    out_ready <= 1'b1;
      DRAIN_COIN:    out_ready <= 1'($urandom_range(0, 1));
      DRAIN_TRICKLE: out_ready <= ($urandom_range(0, 9) == 0);
      default:       out_ready <= 1'b1;
    endcase
  end

  // compare each result transfer with the oldest expected character
  always @(posedge clk) begin : check_result
    char_result_t want;
    char_result_t got;
    if (!rst && out_valid && out_ready) begin
      got = '{cp: code_point, len: seq_length, bad: bad_sequence};
      if (pending_chars.size() == 0) begin
        flag_mismatch("result with nothing expected", '0, got);
      end else begin
        want = pending_chars.pop_front();
        if (got.cp !== want.cp || got.len !== want.len || got.bad !== want.bad)
          flag_mismatch("wrong result", want, got);
      end
    end
  end

  // reset, directed table, random text, drain and verdict
  initial begin : stimulus
    char_result_t r;
    bit           due;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      transfer_byte(directed_rows[i].b);
      due = decode_byte(directed_rows[i].b, r);
      if (directed_rows[i].typed)
        pending_chars.push_back(char_result_t'{cp: directed_rows[i].cp,
                                               len: directed_rows[i].len,
                                               bad: directed_rows[i].bad});
      else if (due)
        pending_chars.push_back(r);
    end

    // random text
    build_random_text();
    foreach (text_bytes[i]) begin
      transfer_byte(text_bytes[i]);
      if (decode_byte(text_bytes[i], r))
        pending_chars.push_back(r);
    end
    in_valid <= 1'b0;

    // let every result arrive, then watch for stray ones
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_chars.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // hard limit on the run
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
